/* rtl/core/ist_pkg.sv */
// Shared types, character constants and helpers of the INI stream tokenizer.
`timescale 1ns / 1ps

package ist_pkg;

  // Fixed field widths of the words on both channels.
  localparam int CmdW      = 2;
  localparam int CharW     = 8;
  localparam int EventW    = 3;
  localparam int KindW     = 3;
  localparam int LineW     = 32;
  localparam int InTdataW  = 8;
  localparam int OutFieldsW = CharW + KindW + LineW + LineW;
  localparam int OutTdataW = ((OutFieldsW + 7) / 8) * 8;

  // At most this many result words leave for one input word.
  localparam int MaxResults = 18;
  // Width of a release length, which never exceeds MaxResults.
  localparam int RelW = $clog2(MaxResults + 1);

  // Characters the parser looks at.
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChLf    = 8'h0A;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChHash  = 8'h23;
  localparam logic [CharW-1:0] ChEq    = 8'h3D;
  localparam logic [CharW-1:0] ChLbr   = 8'h5B;
  localparam logic [CharW-1:0] ChRbr   = 8'h5D;

  typedef enum logic [CmdW-1:0] {
    CMD_DATA    = 2'd0,
    CMD_EOS     = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [EventW-1:0] {
    EV_SCHAR  = 3'd0,
    EV_SBEGIN = 3'd1,
    EV_SEND   = 3'd2,
    EV_KCHAR  = 3'd3,
    EV_VCHAR  = 3'd4,
    EV_KDONE  = 3'd5,
    EV_ERR    = 3'd6
  } event_e;

  typedef enum logic [KindW-1:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_KEY    = 3'd1,
    ERR_SECT_NAME = 3'd2,
    ERR_BRACKET   = 3'd3,
    ERR_LINE_END  = 3'd4,
    ERR_EQUALS    = 3'd5,
    ERR_SPACE     = 3'd6
  } err_kind_e;

  // Parser states; the error states sit at ErrStateBase plus the error kind.
  typedef enum logic [3:0] {
    ST_LINE           = 4'd0,
    ST_LSQ            = 4'd1,
    ST_GNAME          = 4'd2,
    ST_GDONE          = 4'd3,
    ST_EOL            = 4'd4,
    ST_COMMENT        = 4'd5,
    ST_KEY            = 4'd6,
    ST_EQ             = 4'd7,
    ST_VAL            = 4'd8,
    ST_ERR_NO_KEY     = 4'd9,
    ST_ERR_SECT_NAME  = 4'd10,
    ST_ERR_BRACKET    = 4'd11,
    ST_ERR_LINE_END   = 4'd12,
    ST_ERR_EQUALS     = 4'd13,
    ST_ERR_SPACE      = 4'd14
  } parse_state_e;

  localparam logic [3:0] ErrStateBase = 4'd8;

  typedef enum logic [1:0] {
    BL_SPACE = 2'd0,
    BL_TAB   = 2'd1,
    BL_CR    = 2'd2
  } blank_code_e;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_REL  = 2'd1,
    B_EMIT = 2'd2
  } back_state_e;

  // One classified input word, as handed from the front to the back.
  typedef struct packed {
    logic              hold_we;    // store one blank code
    blank_code_e       hold_code;
    logic [RelW-1:0]   rel_n;      // held blanks to release first
    event_e            rel_ev;
    logic              main_vld;   // one char, error or section begin word
    event_e            main_ev;
    logic [CharW-1:0]  main_char;
    err_kind_e         main_kind;
    logic              sbegin;     // unnamed section begins
    logic              kdone;
    logic              send;
    logic [LineW-1:0]  line;
    logic [LineW-1:0]  col;
  } op_t;

  // One result word.
  typedef struct packed {
    event_e            ev;
    logic [CharW-1:0]  ch;
    err_kind_e         kind;
    logic [LineW-1:0]  line;
    logic [LineW-1:0]  col;
    logic              last;
  } res_t;

  function automatic blank_code_e blank_code(logic [CharW-1:0] c);
    blank_code_e code;
    code = BL_SPACE;
    if (c == ChTab) begin
      code = BL_TAB;
    end else if (c == ChCr) begin
      code = BL_CR;
    end
    return code;
  endfunction

  function automatic logic [CharW-1:0] blank_char(logic [1:0] code);
    logic [CharW-1:0] c;
    case (code)
      BL_TAB:  c = ChTab;
      BL_CR:   c = ChCr;
      default: c = ChSpace;
    endcase
    return c;
  endfunction

  function automatic parse_state_e err_state(err_kind_e k);
    return parse_state_e'(ErrStateBase + 4'(k));
  endfunction

  function automatic err_kind_e state_kind(parse_state_e s);
    return err_kind_e'(3'(s - ErrStateBase));
  endfunction

endpackage

/* rtl/core/ini_stream_tokenizer.sv */
// Top level of the INI stream tokenizer: front parser, word queue and result back end.
//
//  Channel   Direction  Ports                 Word contents
//  s_axis    in         tvalid/tready/tdata   tuser: command; tdata: data byte
//  m_axis    out        tvalid/tready/tdata   tuser: event; tdata: char, kind, line, column;
//                                             tlast: final result of its input word
//
// The front takes one input word per cycle while the queue has room. The back end emits
// a word's fixed results one after another; a word that releases held blanks first reads
// the hold RAM, then emits the blanks and then its final char. Blank-hold words make no
// result. Reset clears all control state at once; there is no clearing pass. A stalled
// m_axis fills the queue, after which s_axis_tready drops.
`timescale 1ns / 1ps

module ini_stream_tokenizer #(
  parameter int SPACE_HOLD_DEPTH = 16,
  parameter int QUEUE_DEPTH      = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: [7:0] data_byte
  input  logic [ist_pkg::InTdataW-1:0]    s_axis_tdata,
  // tuser: [1:0] command
  input  logic [ist_pkg::CmdW-1:0]        s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: [7:0] char_out, [10:8] error_kind, [42:11] line_number,
  //        [74:43] column_number, [79:75] zero
  output logic [ist_pkg::OutTdataW-1:0]   m_axis_tdata,
  // tuser: [2:0] event_res
  output logic [ist_pkg::EventW-1:0]      m_axis_tuser,
  // tlast: last_of_run
  output logic                            m_axis_tlast
);

  localparam int IdxW = (SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1;
  localparam int QW   = $bits(ist_pkg::op_t) + IdxW;

  logic                 q_full, q_push, q_pop, q_valid;
  ist_pkg::op_t         push_op;
  logic [IdxW-1:0]      push_idx;
  logic [QW-1:0]        q_head;
  ist_pkg::res_t        res;

  ist_front #(
    .SPACE_HOLD_DEPTH (SPACE_HOLD_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_byte_i  (s_axis_tdata[ist_pkg::CharW-1:0]),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_op_o  (push_op),
    .push_idx_o (push_idx)
  );

  ist_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({push_idx, push_op}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  ist_back #(
    .SPACE_HOLD_DEPTH (SPACE_HOLD_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // Pack the result word.
  assign m_axis_tdata = {{(ist_pkg::OutTdataW - ist_pkg::OutFieldsW){1'b0}},
                         res.col, res.line, res.kind, res.ch};
  assign m_axis_tuser = res.ev;
  assign m_axis_tlast = res.last;

endmodule

/* rtl/core/ist_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ist_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ist_queue.sv */
// Small register FIFO that decouples the front from the back.
`timescale 1ns / 1ps

module ist_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wptr_q + 1'b1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/ist_front.sv */
// Front of the tokenizer: takes input words, runs the line parser and classifies each word.
`timescale 1ns / 1ps

module ist_front #(
  parameter int SPACE_HOLD_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ist_pkg::CmdW-1:0]   in_cmd_i,
  input  logic [ist_pkg::CharW-1:0]  in_byte_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output ist_pkg::op_t               push_op_o,
  output logic [((SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1)-1:0] push_idx_o
);

  localparam int IdxW = (SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1;
  localparam int CntW = $clog2(SPACE_HOLD_DEPTH + 1);

  ist_pkg::parse_state_e         st_q, st_d, f_st;
  logic                          pend_q, pend_d, f_pend;
  logic [CntW-1:0]               cnt_q, cnt_d, f_cnt;
  logic [ist_pkg::LineW-1:0]     line_q, line_d, col_q, col_d;
  logic [ist_pkg::CharW-1:0]     c;
  logic                          eol, blank, accept, fail, err_raise, has_work;
  ist_pkg::err_kind_e            err_kind;
  logic [7:0]                    cnt_ext;
  logic [ist_pkg::RelW-1:0]      rel_cap;
  logic                          main_fits;
  ist_pkg::op_t                  op;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Character class and release length, capped at the result limit.
  always_comb begin
    c = (in_cmd_i == ist_pkg::CMD_EOS) ? ist_pkg::ChNul : in_byte_i;
    eol = (c == ist_pkg::ChLf) || (c == ist_pkg::ChNul);
    blank = (c == ist_pkg::ChSpace) || (c == ist_pkg::ChTab) || (c == ist_pkg::ChCr);
    cnt_ext = 8'(cnt_q);
    rel_cap = (cnt_ext > 8'(ist_pkg::MaxResults)) ? ist_pkg::RelW'(ist_pkg::MaxResults)
                                                  : ist_pkg::RelW'(cnt_ext);
    main_fits = (cnt_ext < 8'(ist_pkg::MaxResults));
  end

  // Parser step for one character.
  always_comb begin
    op = '0;
    op.line = line_q;
    op.col = col_q;
    op.rel_ev = ist_pkg::EV_KCHAR;
    op.main_ev = ist_pkg::EV_KCHAR;
    op.main_char = c;
    op.main_kind = ist_pkg::ERR_NONE;
    op.hold_code = ist_pkg::blank_code(c);
    f_st = st_q;
    f_pend = pend_q;
    f_cnt = cnt_q;
    err_raise = 1'b0;
    err_kind = ist_pkg::ERR_NONE;
    fail = 1'b0;
    case (st_q)
      ist_pkg::ST_LINE: begin
        if (eol || blank) begin
          f_st = st_q;
        end else if (c == ist_pkg::ChHash) begin
          f_st = ist_pkg::ST_COMMENT;
        end else if (c == ist_pkg::ChLbr) begin
          op.send = !pend_q;
          f_st = ist_pkg::ST_LSQ;
        end else if (c == ist_pkg::ChEq) begin
          err_raise = 1'b1;
          err_kind = ist_pkg::ERR_NO_KEY;
        end else begin
          f_cnt = '0;
          op.main_vld = 1'b1;
          f_st = ist_pkg::ST_KEY;
        end
      end
      ist_pkg::ST_LSQ: begin
        if (eol || c == ist_pkg::ChRbr) begin
          err_raise = 1'b1;
          err_kind = ist_pkg::ERR_SECT_NAME;
        end else if (!blank) begin
          op.main_vld = 1'b1;
          op.main_ev = ist_pkg::EV_SCHAR;
          f_st = ist_pkg::ST_GNAME;
        end
      end
      ist_pkg::ST_GNAME: begin
        if (eol) begin
          err_raise = 1'b1;
          err_kind = ist_pkg::ERR_BRACKET;
        end else if (blank) begin
          f_st = ist_pkg::ST_GDONE;
        end else if (c == ist_pkg::ChRbr) begin
          op.main_vld = 1'b1;
          op.main_ev = ist_pkg::EV_SBEGIN;
          op.main_char = ist_pkg::ChNul;
          f_pend = 1'b0;
          f_st = ist_pkg::ST_EOL;
        end else begin
          op.main_vld = 1'b1;
          op.main_ev = ist_pkg::EV_SCHAR;
        end
      end
      ist_pkg::ST_GDONE: begin
        if (c == ist_pkg::ChRbr) begin
          op.main_vld = 1'b1;
          op.main_ev = ist_pkg::EV_SBEGIN;
          op.main_char = ist_pkg::ChNul;
          f_pend = 1'b0;
          f_st = ist_pkg::ST_EOL;
        end else if (!blank) begin
          err_raise = 1'b1;
          err_kind = ist_pkg::ERR_BRACKET;
        end
      end
      ist_pkg::ST_EOL: begin
        if (eol) begin
          f_st = ist_pkg::ST_LINE;
        end else if (!blank) begin
          err_raise = 1'b1;
          err_kind = ist_pkg::ERR_LINE_END;
        end
      end
      ist_pkg::ST_COMMENT: begin
        if (eol) begin
          f_st = ist_pkg::ST_LINE;
        end
      end
      ist_pkg::ST_KEY, ist_pkg::ST_VAL: begin
        if (st_q == ist_pkg::ST_KEY && c == ist_pkg::ChEq) begin
          f_cnt = '0;
          f_st = ist_pkg::ST_EQ;
        end else if (eol) begin
          if (st_q == ist_pkg::ST_KEY) begin
            err_raise = 1'b1;
            err_kind = ist_pkg::ERR_EQUALS;
          end else begin
            f_cnt = '0;
            op.sbegin = pend_q;
            op.kdone = 1'b1;
            f_pend = 1'b0;
            f_st = ist_pkg::ST_LINE;
          end
        end else if (blank) begin
          if (cnt_q >= CntW'(SPACE_HOLD_DEPTH)) begin
            err_raise = 1'b1;
            err_kind = ist_pkg::ERR_SPACE;
          end else begin
            op.hold_we = 1'b1;
            f_cnt = CntW'(cnt_q + 1'b1);
          end
        end else begin
          // Held blanks go out in front of this character.
          op.rel_n = rel_cap;
          op.rel_ev = (st_q == ist_pkg::ST_KEY) ? ist_pkg::EV_KCHAR : ist_pkg::EV_VCHAR;
          op.main_vld = main_fits;
          op.main_ev = op.rel_ev;
          f_cnt = '0;
        end
      end
      ist_pkg::ST_EQ: begin
        if (eol) begin
          f_cnt = '0;
          op.sbegin = pend_q;
          op.kdone = 1'b1;
          f_pend = 1'b0;
          f_st = ist_pkg::ST_LINE;
        end else if (!blank) begin
          f_cnt = '0;
          op.main_vld = 1'b1;
          op.main_ev = ist_pkg::EV_VCHAR;
          f_st = ist_pkg::ST_VAL;
        end
      end
      ist_pkg::ST_ERR_NO_KEY, ist_pkg::ST_ERR_SECT_NAME, ist_pkg::ST_ERR_BRACKET,
      ist_pkg::ST_ERR_LINE_END, ist_pkg::ST_ERR_EQUALS, ist_pkg::ST_ERR_SPACE: begin
        // Sticky error: repeat the same error word.
        op.main_vld = 1'b1;
        op.main_ev = ist_pkg::EV_ERR;
        op.main_char = ist_pkg::ChNul;
        op.main_kind = ist_pkg::state_kind(st_q);
        fail = 1'b1;
      end
      default: begin
        f_st = ist_pkg::ST_LINE;
      end
    endcase
    if (err_raise) begin
      f_st = ist_pkg::err_state(err_kind);
      op.hold_we = 1'b0;
      op.main_vld = 1'b1;
      op.main_ev = ist_pkg::EV_ERR;
      op.main_char = ist_pkg::ChNul;
      op.main_kind = err_kind;
      fail = 1'b1;
    end
    if (!op.main_vld || op.main_ev == ist_pkg::EV_SBEGIN || op.main_ev == ist_pkg::EV_ERR) begin
      op.main_char = ist_pkg::ChNul;
    end
  end

  // Command handling, position counters and the word handed to the queue.
  always_comb begin
    st_d = st_q;
    pend_d = pend_q;
    cnt_d = cnt_q;
    line_d = line_q;
    col_d = col_q;
    push_op_o = op;
    push_o = 1'b0;
    has_work = op.hold_we || (op.rel_n != '0) || op.main_vld || op.sbegin || op.kdone
               || op.send;
    if (accept) begin
      case (in_cmd_i)
        ist_pkg::CMD_DATA: begin
          st_d = f_st;
          pend_d = f_pend;
          cnt_d = f_cnt;
          push_o = has_work;
          if (!fail) begin
            if (c == ist_pkg::ChLf) begin
              if (line_q != '1) begin
                line_d = ist_pkg::LineW'(line_q + 1'b1);
              end
              col_d = ist_pkg::LineW'(1);
            end else if (col_q != '1) begin
              col_d = ist_pkg::LineW'(col_q + 1'b1);
            end
          end
        end
        ist_pkg::CMD_EOS: begin
          if (fail) begin
            st_d = f_st;
            pend_d = f_pend;
            cnt_d = f_cnt;
            push_o = 1'b1;
          end else begin
            push_op_o.send = !f_pend;
            push_o = has_work || !f_pend;
            st_d = ist_pkg::ST_LINE;
            pend_d = 1'b1;
            cnt_d = '0;
            line_d = ist_pkg::LineW'(1);
            col_d = ist_pkg::LineW'(1);
          end
        end
        ist_pkg::CMD_RESTART: begin
          st_d = ist_pkg::ST_LINE;
          pend_d = 1'b1;
          cnt_d = '0;
          line_d = ist_pkg::LineW'(1);
          col_d = ist_pkg::LineW'(1);
        end
        default: begin
          st_d = st_q;
        end
      endcase
    end
  end

  assign push_idx_o = cnt_q[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ist_pkg::ST_LINE;
      pend_q <= 1'b1;
      cnt_q <= '0;
      line_q <= ist_pkg::LineW'(1);
      col_q <= ist_pkg::LineW'(1);
    end else begin
      st_q <= st_d;
      pend_q <= pend_d;
      cnt_q <= cnt_d;
      line_q <= line_d;
      col_q <= col_d;
    end
  end

endmodule

/* rtl/core/ist_back.sv */
// Back of the tokenizer: keeps the held blanks and expands each classified word into results.
`timescale 1ns / 1ps

module ist_back #(
  parameter int SPACE_HOLD_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  logic [$bits(ist_pkg::op_t)
                + ((SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1) - 1:0] q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ist_pkg::res_t        out_res_o
);

  localparam int IdxW = (SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1;
  localparam int OpW  = $bits(ist_pkg::op_t);
  localparam int QW   = OpW + IdxW;

  ist_pkg::back_state_e       st_q, st_d;
  ist_pkg::op_t               cur_q, cur_d, head_op, pick, rem;
  logic [IdxW-1:0]            head_idx;
  logic [ist_pkg::RelW-1:0]   idx_q, idx_d, idx_inc;
  logic                       out_vld_q, out_vld_d, can_adv, emit, rem_any, rel_final;
  ist_pkg::res_t              res_q, res_d, sel;
  logic [1:0]                 ram_rdata;
  logic                       ram_we;

  assign head_op  = ist_pkg::op_t'(q_head_i[OpW-1:0]);
  assign head_idx = q_head_i[QW-1 -: IdxW];
  assign can_adv  = !out_vld_q || out_ready_i;
  assign idx_inc  = ist_pkg::RelW'(idx_q + 1'b1);
  assign rel_final = (idx_inc == cur_q.rel_n);

  // Held blank codes, written in order by hold words.
  ist_ram #(
    .WIDTH (2),
    .DEPTH (SPACE_HOLD_DEPTH)
  ) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_idx),
    .wdata_i (head_op.hold_code),
    .raddr_i (IdxW'(idx_d)),
    .rdata_o (ram_rdata)
  );

  // Next pending fixed word of the current classified word.
  always_comb begin
    pick = (st_q == ist_pkg::B_IDLE) ? head_op : cur_q;
    rem = pick;
    sel = '0;
    sel.line = pick.line;
    sel.col = pick.col;
    sel.kind = ist_pkg::ERR_NONE;
    sel.ev = ist_pkg::EV_SEND;
    if (pick.main_vld) begin
      sel.ev = pick.main_ev;
      sel.ch = pick.main_char;
      sel.kind = pick.main_kind;
      rem.main_vld = 1'b0;
    end else if (pick.sbegin) begin
      sel.ev = ist_pkg::EV_SBEGIN;
      rem.sbegin = 1'b0;
    end else if (pick.kdone) begin
      sel.ev = ist_pkg::EV_KDONE;
      rem.kdone = 1'b0;
    end else begin
      rem.send = 1'b0;
    end
    rem_any = rem.main_vld || rem.sbegin || rem.kdone || rem.send;
    sel.last = !rem_any;
  end

  // Sequencer over hold, release and fixed result words.
  always_comb begin
    st_d = st_q;
    cur_d = cur_q;
    idx_d = idx_q;
    q_pop_o = 1'b0;
    ram_we = 1'b0;
    emit = 1'b0;
    res_d = sel;
    case (st_q)
      ist_pkg::B_IDLE: begin
        idx_d = '0;
        if (q_valid_i) begin
          if (head_op.hold_we) begin
            ram_we = 1'b1;
            q_pop_o = 1'b1;
          end else if (head_op.rel_n != '0) begin
            q_pop_o = 1'b1;
            cur_d = head_op;
            st_d = ist_pkg::B_REL;
          end else if (can_adv) begin
            q_pop_o = 1'b1;
            emit = 1'b1;
            cur_d = rem;
            if (rem_any) begin
              st_d = ist_pkg::B_EMIT;
            end
          end
        end
      end
      ist_pkg::B_REL: begin
        res_d.ev = cur_q.rel_ev;
        res_d.ch = ist_pkg::blank_char(ram_rdata);
        res_d.kind = ist_pkg::ERR_NONE;
        res_d.line = cur_q.line;
        res_d.col = cur_q.col;
        res_d.last = rel_final && !cur_q.main_vld;
        if (can_adv) begin
          emit = 1'b1;
          if (rel_final) begin
            idx_d = '0;
            st_d = cur_q.main_vld ? ist_pkg::B_EMIT : ist_pkg::B_IDLE;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      ist_pkg::B_EMIT: begin
        if (can_adv) begin
          emit = 1'b1;
          cur_d = rem;
          if (!rem_any) begin
            st_d = ist_pkg::B_IDLE;
          end
        end
      end
      default: begin
        st_d = ist_pkg::B_IDLE;
      end
    endcase
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ist_pkg::B_IDLE;
      idx_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      idx_q <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = res_q;

endmodule

/* rtl/core/ist_checker.sv */
// Port-level checks of the INI stream tokenizer, bound to the top level.
`timescale 1ns / 1ps

module ist_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ist_pkg::OutTdataW-1:0]  m_axis_tdata,
  input logic [ist_pkg::EventW-1:0]     m_axis_tuser,
  input logic                           m_axis_tlast
);

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // Only character words carry a character.
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ist_pkg::EV_SCHAR && m_axis_tuser != ist_pkg::EV_KCHAR
      && m_axis_tuser != ist_pkg::EV_VCHAR |-> m_axis_tdata[7:0] == '0)
    else $error("non-character word carries a character");

  // An error kind appears exactly on error words.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == ist_pkg::EV_ERR) == (m_axis_tdata[10:8] != '0)))
    else $error("error kind does not match the event");

  // Line and column count from one.
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[42:11] != '0 && m_axis_tdata[74:43] != '0)
    else $error("line or column is zero");

  // A section end is always the final result of its input word.
  a_send_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ist_pkg::EV_SEND |-> m_axis_tlast)
    else $error("section end is not the final result");

endmodule

bind ini_stream_tokenizer ist_checker u_ist_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* verif/testbench.sv */
// Self-checking testbench of the INI stream tokenizer with its own parser predictor.
`timescale 1ns / 1ps

module testbench;
  import ist_pkg::*;

  localparam int HoldDepth   = 16;
  localparam int RandomWords = 450;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 40;
  localparam logic [CmdW-1:0] CmdUnknown = 2'd3;

  // One input word, with an optional hand-written expectation of a single error word.
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [CharW-1:0] ch;
    logic             typed;
    event_e           ev;
    err_kind_e        kind;
  } stim_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic [CmdW-1:0]      s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [EventW-1:0]    m_axis_tuser;
  logic                 m_axis_tlast;

  // Predictor state of the parser.
  parse_state_e     pstate;
  logic             anon_pending;
  logic [CharW-1:0] held_blanks [HoldDepth];
  int               held_n;
  logic [LineW-1:0] line_cnt;
  logic [LineW-1:0] col_cnt;

  res_t  step_events[$];
  res_t  expected_events[$];
  stim_t byte_stream[$];

  int tx_idle_pct  = 7;
  int rx_idle_pct  = 71;
  int fail_count   = 0;
  int stall_cycles = 0;
  bit file_broken;

  // Directed words: reset values, extreme bytes, every command and three of the error codes.
  stim_t directed_rows [26] = '{
    // A stray equals sign at the very start, then the error sticks.
    '{CMD_DATA,    ChEq,   1'b1, EV_ERR,   ERR_NO_KEY},
    '{CMD_DATA,    8'hFF,  1'b1, EV_ERR,   ERR_NO_KEY},
    '{CmdUnknown,  8'h00,  1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_RESTART, 8'hA5,  1'b0, EV_SCHAR, ERR_NONE},
    // An empty header; end of stream does not clear the error.
    '{CMD_DATA,    ChLbr,  1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    ChRbr,  1'b1, EV_ERR,   ERR_SECT_NAME},
    '{CMD_EOS,     8'h5A,  1'b1, EV_ERR,   ERR_SECT_NAME},
    '{CMD_RESTART, 8'h00,  1'b0, EV_SCHAR, ERR_NONE},
    // Header " [# ]" with a hash inside the name.
    '{CMD_DATA,    ChSpace, 1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    ChLbr,  1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    ChHash, 1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    ChSpace, 1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    ChRbr,  1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    ChLf,   1'b0, EV_SCHAR, ERR_NONE},
    // Key with inner blanks, value with a trailing blank, line ended by a NUL.
    '{CMD_DATA,    8'h6B,  1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    ChTab,  1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    ChCr,   1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    8'hFF,  1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    ChEq,   1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    8'h76,  1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    ChSpace, 1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    ChNul,  1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_EOS,     8'hFF,  1'b0, EV_SCHAR, ERR_NONE},
    // A key that runs into the line end.
    '{CMD_DATA,    8'h78,  1'b0, EV_SCHAR, ERR_NONE},
    '{CMD_DATA,    ChLf,   1'b1, EV_ERR,   ERR_EQUALS},
    '{CMD_RESTART, 8'h00,  1'b0, EV_SCHAR, ERR_NONE}
  };

  ini_stream_tokenizer #(
    .SPACE_HOLD_DEPTH(HoldDepth)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  always #6 clk_i = ~clk_i;

  // Predictor: parser state handling.
  function automatic void reset_parser();
    pstate       = ST_LINE;
    anon_pending = 1'b1;
    held_n       = 0;
    line_cnt     = 1;
    col_cnt      = 1;
  endfunction

  function automatic void add_event(event_e ev, logic [CharW-1:0] c, err_kind_e kind);
    if (step_events.size() < MaxResults) begin
      step_events.push_back('{ev, c, kind, line_cnt, col_cnt, 1'b0});
    end
  endfunction

  function automatic bit flag_error(err_kind_e kind);
    pstate = parse_state_e'(ErrStateBase + 4'(kind));
    add_event(EV_ERR, ChNul, kind);
    return 1'b0;
  endfunction

  function automatic bit hold_blank(logic [CharW-1:0] c);
    if (held_n >= HoldDepth) begin
      return flag_error(ERR_SPACE);
    end
    held_blanks[held_n] = c;
    held_n++;
    return 1'b1;
  endfunction

  function automatic void release_blanks(event_e ev);
    for (int i = 0; i < held_n; i++) begin
      add_event(ev, held_blanks[i], ERR_NONE);
    end
    held_n = 0;
  endfunction

  function automatic void open_section();
    add_event(EV_SBEGIN, ChNul, ERR_NONE);
    anon_pending = 1'b0;
    pstate       = ST_EOL;
  endfunction

  function automatic void finish_key();
    held_n = 0;
    if (anon_pending) begin
      add_event(EV_SBEGIN, ChNul, ERR_NONE);
      anon_pending = 1'b0;
    end
    add_event(EV_KDONE, ChNul, ERR_NONE);
    pstate = ST_LINE;
  endfunction

  // Predictor: one character through the line parser; returns 0 once in error.
  function automatic bit parse_char(logic [CharW-1:0] c);
    bit eol;
    bit blank;
    eol   = (c == ChLf) || (c == ChNul);
    blank = (c == ChSpace) || (c == ChTab) || (c == ChCr);
    case (pstate)
      ST_LINE: begin
        if (eol || blank) return 1'b1;
        if (c == ChHash) begin
          pstate = ST_COMMENT;
          return 1'b1;
        end
        if (c == ChLbr) begin
          if (!anon_pending) add_event(EV_SEND, ChNul, ERR_NONE);
          pstate = ST_LSQ;
          return 1'b1;
        end
        if (c == ChEq) return flag_error(ERR_NO_KEY);
        held_n = 0;
        add_event(EV_KCHAR, c, ERR_NONE);
        pstate = ST_KEY;
        return 1'b1;
      end
      ST_LSQ: begin
        if (eol || c == ChRbr) return flag_error(ERR_SECT_NAME);
        if (blank) return 1'b1;
        add_event(EV_SCHAR, c, ERR_NONE);
        pstate = ST_GNAME;
        return 1'b1;
      end
      ST_GNAME: begin
        if (eol) return flag_error(ERR_BRACKET);
        if (blank) begin
          pstate = ST_GDONE;
        end else if (c == ChRbr) begin
          open_section();
        end else begin
          add_event(EV_SCHAR, c, ERR_NONE);
        end
        return 1'b1;
      end
      ST_GDONE: begin
        if (c == ChRbr) begin
          open_section();
          return 1'b1;
        end
        if (blank) return 1'b1;
        return flag_error(ERR_BRACKET);
      end
      ST_EOL: begin
        if (eol) begin
          pstate = ST_LINE;
          return 1'b1;
        end
        if (blank) return 1'b1;
        return flag_error(ERR_LINE_END);
      end
      ST_COMMENT: begin
        if (eol) pstate = ST_LINE;
        return 1'b1;
      end
      ST_KEY: begin
        if (c == ChEq) begin
          held_n = 0;
          pstate = ST_EQ;
          return 1'b1;
        end
        if (eol) return flag_error(ERR_EQUALS);
        if (blank) return hold_blank(c);
        release_blanks(EV_KCHAR);
        add_event(EV_KCHAR, c, ERR_NONE);
        return 1'b1;
      end
      ST_EQ: begin
        if (eol) begin
          finish_key();
        end else if (!blank) begin
          held_n = 0;
          add_event(EV_VCHAR, c, ERR_NONE);
          pstate = ST_VAL;
        end
        return 1'b1;
      end
      ST_VAL: begin
        if (eol) begin
          finish_key();
          return 1'b1;
        end
        if (blank) return hold_blank(c);
        release_blanks(EV_VCHAR);
        add_event(EV_VCHAR, c, ERR_NONE);
        return 1'b1;
      end
      default: begin
        // Sticky error: every character repeats the error word.
        add_event(EV_ERR, ChNul, err_kind_e'(3'(pstate - ErrStateBase)));
        return 1'b0;
      end
    endcase
  endfunction

  // Predictor: all result words of one accepted input word, left in step_events.
  function automatic void tokenize_word(logic [CmdW-1:0] cmd, logic [CharW-1:0] c);
    step_events.delete();
    if (cmd == CMD_DATA) begin
      if (parse_char(c)) begin
        if (c == ChLf) begin
          if (line_cnt != '1) line_cnt++;
          col_cnt = 1;
        end else if (col_cnt != '1) begin
          col_cnt++;
        end
      end
    end else if (cmd == CMD_EOS) begin
      if (parse_char(ChNul)) begin
        if (!anon_pending) add_event(EV_SEND, ChNul, ERR_NONE);
        reset_parser();
      end
    end else if (cmd == CMD_RESTART) begin
      reset_parser();
    end
    if (step_events.size() != 0) begin
      step_events[step_events.size() - 1].last = 1'b1;
    end
  endfunction

  // Random text generation, one line at a time.
  function automatic void push_item(logic [CmdW-1:0] cmd, logic [CharW-1:0] c);
    byte_stream.push_back('{cmd, c, 1'b0, EV_SCHAR, ERR_NONE});
  endfunction

  function automatic void push_blanks(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(2))
        0: push_item(CMD_DATA, ChSpace);
        1: push_item(CMD_DATA, ChTab);
        default: push_item(CMD_DATA, ChCr);
      endcase
    end
  endfunction

  // Mostly short blank runs; now and then one long enough to fill or overflow the hold buffer.
  function automatic int run_len();
    if ($urandom_range(29) == 0) begin
      file_broken = 1'b1;
      return int'($urandom_range(HoldDepth + 2, HoldDepth - 1));
    end
    return int'($urandom_range(2));
  endfunction

  function automatic logic [CharW-1:0] pick_text();
    logic [CharW-1:0] c;
    do begin
      if ($urandom_range(9) == 0) begin
        c = CharW'($urandom_range(255, 128));
      end else begin
        c = CharW'($urandom_range(126, 33));
      end
    end while (c == ChHash || c == ChLbr || c == ChRbr || c == ChEq);
    return c;
  endfunction

  function automatic void push_text(int len, bit inner_blanks, bit punct);
    for (int i = 0; i < len; i++) begin
      if (inner_blanks && i > 0 && $urandom_range(3) == 0) push_blanks(run_len());
      if (punct && $urandom_range(5) == 0) begin
        case ($urandom_range(2))
          0: push_item(CMD_DATA, ChLbr);
          1: push_item(CMD_DATA, ChHash);
          default: push_item(CMD_DATA, ChEq);
        endcase
      end else begin
        push_item(CMD_DATA, pick_text());
      end
    end
  endfunction

  function automatic void push_line();
    logic [CharW-1:0] c;
    push_blanks($urandom_range(2));
    case ($urandom_range(9))
      0: ;
      1: begin
        // Comment with arbitrary bytes up to the line end.
        push_item(CMD_DATA, ChHash);
        repeat ($urandom_range(6)) begin
          c = CharW'($urandom_range(255, 1));
          push_item(CMD_DATA, (c == ChLf) ? ChSpace : c);
        end
      end
      2: begin
        push_item(CMD_DATA, ChLbr);
        push_blanks($urandom_range(1));
        push_text($urandom_range(5, 1), 1'b0, 1'b1);
        push_blanks($urandom_range(1));
        push_item(CMD_DATA, ChRbr);
        push_blanks($urandom_range(1));
      end
      8: begin
        // Broken lines of every error kind, or plain noise.
        file_broken = 1'b1;
        case ($urandom_range(5))
          0: repeat ($urandom_range(8, 1)) push_item(CMD_DATA, CharW'($urandom_range(255)));
          1: push_item(CMD_DATA, ChLbr);
          2: begin
            push_item(CMD_DATA, ChLbr);
            push_text(2, 1'b0, 1'b0);
          end
          3: begin
            push_item(CMD_DATA, ChLbr);
            push_text(2, 1'b0, 1'b0);
            push_item(CMD_DATA, ChRbr);
            push_blanks(1);
            push_text(1, 1'b0, 1'b0);
          end
          4: push_text(3, 1'b1, 1'b0);
          default: push_item(CMD_DATA, ChEq);
        endcase
      end
      default: begin
        push_text($urandom_range(5, 1), 1'b1, 1'b0);
        push_blanks(run_len());
        push_item(CMD_DATA, ChEq);
        push_blanks($urandom_range(2));
        push_text($urandom_range(6), 1'b1, 1'b1);
        push_blanks(run_len());
      end
    endcase
    push_item(CMD_DATA, ($urandom_range(7) == 0) ? ChNul : ChLf);
  endfunction

  function automatic void push_file();
    file_broken = 1'b0;
    repeat ($urandom_range(6, 2)) push_line();
    push_item(CMD_EOS, CharW'($urandom));
    if (file_broken || $urandom_range(3) == 0) push_item(CMD_RESTART, CharW'($urandom));
    if ($urandom_range(15) == 0) push_item(CmdUnknown, CharW'($urandom));
  endfunction

  // Idle pattern by position in the run: sender rarely, then receiver rarely, then none.
  function automatic void set_idle(int k, int total);
    case ((3 * k) / total)
      0: begin
        tx_idle_pct = 7;
        rx_idle_pct = 71;
      end
      1: begin
        tx_idle_pct = 71;
        rx_idle_pct = 7;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endfunction

  // Drive one word, wait for its acceptance and queue what it should produce.
  task automatic send_word(stim_t w);
    res_t fixed_word;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.cmd;
    s_axis_tdata  <= w.ch;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fixed_word = '{w.ev, ChNul, w.kind, line_cnt, col_cnt, 1'b1};
    tokenize_word(w.cmd, w.ch);
    if (w.typed) begin
      expected_events.push_back(fixed_word);
    end else begin
      foreach (step_events[i]) expected_events.push_back(step_events[i]);
    end
  endtask

  task automatic report_diff(string field, logic [LineW-1:0] want, logic [LineW-1:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    fail_count++;
  endtask

  // Receiver: random back-pressure and field-by-field comparison of each result word.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    if (m_axis_tvalid && m_axis_tready) begin
      got.ev   = event_e'(m_axis_tuser);
      got.ch   = m_axis_tdata[7:0];
      got.kind = err_kind_e'(m_axis_tdata[10:8]);
      got.line = m_axis_tdata[42:11];
      got.col  = m_axis_tdata[74:43];
      got.last = m_axis_tlast;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual event %0d char %0h kind %0d",
                 $time, got.ev, got.ch, got.kind);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        if (got.ev !== want.ev) report_diff("event", LineW'(want.ev), LineW'(got.ev));
        if (got.ch !== want.ch) report_diff("char", LineW'(want.ch), LineW'(got.ch));
        if (got.kind !== want.kind) report_diff("kind", LineW'(want.kind), LineW'(got.kind));
        if (got.line !== want.line) report_diff("line", want.line, got.line);
        if (got.col !== want.col) report_diff("column", want.col, got.col);
        if (got.last !== want.last) report_diff("last", LineW'(want.last), LineW'(got.last));
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Main sequence: reset, directed words, random text, drain and verdict.
  initial begin
    int total;
    reset_parser();
    while (byte_stream.size() < RandomWords) push_file();
    total = $size(directed_rows) + byte_stream.size();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[i]) begin
      set_idle(i, total);
      send_word(directed_rows[i]);
    end
    foreach (byte_stream[i]) begin
      set_idle($size(directed_rows) + i, total);
      send_word(byte_stream[i]);
    end
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
